/* rtl/stepper_full_step_sequencer_top_assert.svh */
// Assertion macros shared by the stepper sequencer RTL.
// All checks sample on the rising clock edge and are held off during reset.
`ifndef STEPPER_FULL_STEP_SEQUENCER_TOP_ASSERT_SVH
`define STEPPER_FULL_STEP_SEQUENCER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that prop holds on every clock edge out of reset.
`define STFS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define STFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define STFS_ASSERT(label, clk, rst_n, prop, msg)
`define STFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/stfs_pkg.sv */
package stfs_pkg;

  // Item kinds carried in tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_STEP_INTERVAL = 2'd0;
  localparam logic [1:0] REG_TARGET_STEPS  = 2'd1;
  localparam logic [1:0] REG_DIRECTION_FWD = 2'd2;
  localparam logic [1:0] REG_LIMIT_ENABLED = 2'd3;

  localparam int unsigned FIELD_W = 24;

  // Coil pattern per phase, forward order, bit i drives coil i
  localparam logic [3:0] COIL_TABLE [4] = '{4'b1001, 4'b1100, 4'b0110, 4'b0011};

  typedef struct packed {
    logic [FIELD_W-1:0] step_interval;
    logic [FIELD_W-1:0] target_steps;
    logic               direction_forward;
    logic               limit_enabled;
  } stfs_cfg_t;

  // Packed so that coil_drive sits in the lowest bits
  typedef struct packed {
    logic [FIELD_W-1:0] steps_done;
    logic               moving;
    logic               limit_hit;
    logic               move_done;
    logic               stepped;
    logic [3:0]         coil_drive;
  } stfs_result_t;

  // Reverse the coil order when running backwards
  function automatic logic [3:0] coil_pattern(input logic [1:0] ph, input logic fwd);
    logic [3:0] pat;
    pat = COIL_TABLE[ph];
    return fwd ? pat : {pat[0], pat[1], pat[2], pat[3]};
  endfunction

endpackage

/* rtl/stfs_core.sv */
`include "stepper_full_step_sequencer_top_assert.svh"

module stfs_core import stfs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         acc_i,
  input  logic         opcode_i,
  input  logic         limit_level_i,
  input  stfs_cfg_t    cfg_i,
  output stfs_result_t result_o
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;

  logic [1:0]             phase_q, phase_d;
  logic                   busy_q, busy_d;
  logic                   last_limit_q, last_limit_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d, total_inc;
  logic [FIELD_W-1:0]     wait_q, wait_d;
  logic [3:0]             coil_q, coil_d;
  logic                   stepped, done, hit;
  logic                   start;

  // Saturating step count
  assign total_inc = (&total_q) ? total_q : total_q + COUNT_WIDTH'(1);
  assign start     = (opcode_i == OP_START);

  // Work out next state and result of one item
  always_comb begin
    phase_d      = phase_q;
    busy_d       = busy_q;
    last_limit_d = last_limit_q;
    total_d      = total_q;
    wait_d       = wait_q;
    coil_d       = coil_q;
    stepped      = 1'b0;
    done         = 1'b0;
    hit          = 1'b0;
    if (start) begin
      if (!busy_q) begin
        last_limit_d = limit_level_i;
        total_d      = '0;
        phase_d      = 2'd0;
        wait_d       = '0;
        busy_d       = 1'b1;
      end
    end else if (busy_q) begin
      if (wait_q == '0) begin
        phase_d = phase_q + 2'd1;
        coil_d  = coil_pattern(phase_d, cfg_i.direction_forward);
        stepped = 1'b1;
        total_d = total_inc;
        if ((cfg_i.target_steps != '0) &&
            (CMP_W'(total_inc) >= CMP_W'(cfg_i.target_steps))) begin
          busy_d = 1'b0;
          done   = 1'b1;
        end else if (cfg_i.limit_enabled && !last_limit_q && limit_level_i) begin
          busy_d = 1'b0;
          done   = 1'b1;
          hit    = 1'b1;
        end else begin
          if (cfg_i.limit_enabled) begin
            last_limit_d = limit_level_i;
          end
          wait_d = cfg_i.step_interval;
        end
      end else begin
        wait_d = wait_q - FIELD_W'(1);
      end
    end
  end

  // Assemble the result beat from the next state
  always_comb begin
    result_o.coil_drive = coil_d;
    result_o.stepped    = stepped;
    result_o.move_done  = done;
    result_o.limit_hit  = hit;
    result_o.moving     = busy_d;
    result_o.steps_done = (CMP_W'(total_d) > CMP_W'({FIELD_W{1'b1}})) ?
                          {FIELD_W{1'b1}} : FIELD_W'(total_d);
  end

  // Hold state between accepted beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= 2'd0;
      busy_q       <= 1'b0;
      last_limit_q <= 1'b0;
      total_q      <= '0;
      wait_q       <= '0;
      coil_q       <= 4'd0;
    end else if (acc_i) begin
      phase_q      <= phase_d;
      busy_q       <= busy_d;
      last_limit_q <= last_limit_d;
      total_q      <= total_d;
      wait_q       <= wait_d;
      coil_q       <= coil_d;
    end
  end

  `STFS_ASSERT_NEXT(a_start_arms, clk_i, rst_ni, acc_i && start && !busy_q, busy_q, "start did not arm a move")
  `STFS_ASSERT_NEXT(a_wait_no_step, clk_i, rst_ni, acc_i && !start && busy_q && (wait_q != '0), (total_q == $past(total_q)) && (coil_q == $past(coil_q)), "step taken while waiting")
  `STFS_ASSERT_NEXT(a_count_rises, clk_i, rst_ni, acc_i && busy_q, total_q >= $past(total_q), "step count fell during a move")

endmodule

/* rtl/stfs_out_reg.sv */
`include "stepper_full_step_sequencer_top_assert.svh"

module stfs_out_reg import stfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         acc_i,
  input  stfs_result_t result_i,
  input  logic         m_ready_i,
  output logic         m_valid_o,
  output logic         free_o,
  output stfs_result_t result_o
);

  logic         valid_q;
  stfs_result_t data_q;

  // Room for a new beat when empty or when the held one leaves now
  assign free_o    = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;
  assign result_o  = data_q;

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (acc_i) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      data_q <= result_i;
    end
  end

  `STFS_ASSERT_NEXT(a_beat_shown, clk_i, rst_ni, acc_i, valid_q, "accepted beat not presented")
  `STFS_ASSERT(a_accept_free, clk_i, rst_ni, !acc_i || free_o, "beat accepted into a full output register")

endmodule

/* rtl/stepper_full_step_sequencer_top.sv */
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tuser: opcode; tdata: limit_level, 7 bits zero
// m_axis    out  tdata: coil_drive[3:0], stepped, move_done, limit_hit, moving,
//                steps_done[23:0]
// cfg       in   write enable, register index, 24-bit data; no read-back
//
// One input beat per cycle while the output drains; its result beat appears in the cycle
// after accept, computed in a single pass between the input and the output register.
// Input is taken whenever the output register is empty or being drained.
// A stalled output holds its beat and back-pressures the input only then.
// Reset is asynchronous, active low; configuration resets to forward,
// zero interval, no target and limit disabled.
module stepper_full_step_sequencer_top import stfs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // limit_level, 7 bits zero
  input  logic         s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // coil_drive, stepped, move_done, limit_hit,
                                       // moving, steps_done
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_wdata_i
);

  stfs_cfg_t    cfg_q;
  stfs_result_t core_res;
  stfs_result_t out_res;
  logic         free;
  logic         acc;

  assign s_axis_tready = free;
  assign acc           = s_axis_tvalid && free;
  assign m_axis_tdata  = out_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_interval     <= '0;
      cfg_q.target_steps      <= '0;
      cfg_q.direction_forward <= 1'b1;
      cfg_q.limit_enabled     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP_INTERVAL: cfg_q.step_interval     <= cfg_wdata_i;
        REG_TARGET_STEPS:  cfg_q.target_steps      <= cfg_wdata_i;
        REG_DIRECTION_FWD: cfg_q.direction_forward <= cfg_wdata_i[0];
        REG_LIMIT_ENABLED: cfg_q.limit_enabled     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  stfs_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .opcode_i     (s_axis_tuser),
    .limit_level_i(s_axis_tdata[0]),
    .cfg_i        (cfg_q),
    .result_o     (core_res)
  );

  stfs_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .result_i (core_res),
    .m_ready_i(m_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .free_o   (free),
    .result_o (out_res)
  );

endmodule
